// ===== hdl/absolute_trapezoid_move_macros.svh =====
// Assertion macros used by the checker file of the trapezoid move block.
`ifndef ABSOLUTE_TRAPEZOID_MOVE_MACROS_SVH
`define ABSOLUTE_TRAPEZOID_MOVE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ATM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("trapezoid move check failed");

// Next-cycle implication, disabled during reset.
`define ATM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("trapezoid move check failed");

`endif

// ===== hdl/atm_pkg.sv =====
// Package with constants and types of the trapezoid move block.
package atm_pkg;

  localparam int NUM_JOINTS = 4;
  localparam int TICK_BITS  = 24;
  localparam int JOINT_W    = 2;

  localparam logic [47:0] PI_Q40    = 48'h03243F6A8886;
  localparam logic [31:0] DUR_SCALE = 32'd655360000;
  localparam logic [TICK_BITS-1:0] TICK_MAX = {TICK_BITS{1'b1}};

  localparam logic [1:0] CFG_DOUBLE = 2'd0;
  localparam logic [1:0] CFG_ACCEL  = 2'd1;
  localparam logic [1:0] CFG_SETTLE = 2'd2;
  localparam logic [1:0] CFG_MINDUR = 2'd3;

  typedef enum logic [11:0] {
    ST_IDLE   = 12'b000000000001,
    ST_DMAX   = 12'b000000000010,
    ST_TMUL   = 12'b000000000100,
    ST_TDIV   = 12'b000000001000,
    ST_DUR    = 12'b000000010000,
    ST_LIMS   = 12'b000000100000,
    ST_DPROD  = 12'b000001000000,
    ST_JLOAD  = 12'b000010000000,
    ST_JDIV   = 12'b000100000000,
    ST_JSTORE = 12'b001000000000,
    ST_TUPD   = 12'b010000000000,
    ST_TOUT   = 12'b100000000000
  } state_t;

  typedef logic signed [47:0] q40_t;
  typedef logic signed [63:0] acc_t;

endpackage

// ===== hdl/absolute_trapezoid_move.sv =====
// Top level of the four-joint absolute trapezoidal move generator.
// Channel  Direction  Handshake            Payload
// in_      input      in_valid/in_stall    action, start_pos_0..3, target_0..3
// out_     output     out_valid/out_stall  joint, position, velocity, acceleration, last, finished
// cfg_     input      cfg_we               cfg_index, cfg_data
// A start request runs one 64-step restoring divider, which is shared by the duration division
// and the four joint acceleration divisions.
// A tick request steps each joint through ST_TUPD and ST_TOUT in turn; ST_TOUT waits while
// the output is stalled. Configuration returns to its defaults on reset.
// Reset is synchronous and clears the tick, timing and per-joint motion state, but not dist_r.
// The output register lets a new request be accepted while the last result waits.
module absolute_trapezoid_move import atm_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_action,
  input  logic signed [31:0]  in_start_pos_0,
  input  logic signed [31:0]  in_start_pos_1,
  input  logic signed [31:0]  in_start_pos_2,
  input  logic signed [31:0]  in_start_pos_3,
  input  logic signed [31:0]  in_target_0,
  input  logic signed [31:0]  in_target_1,
  input  logic signed [31:0]  in_target_2,
  input  logic signed [31:0]  in_target_3,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          out_joint,
  output logic signed [31:0]  out_position,
  output logic signed [47:0]  out_velocity,
  output logic signed [47:0]  out_acceleration,
  output logic                out_last,
  output logic                out_finished,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data
);

  localparam logic signed [63:0] MAX48 = 64'sh00007FFFFFFFFFFF;
  localparam logic signed [63:0] MIN48 = -MAX48 - 64'sd1;

  function automatic q40_t sat48(input logic signed [63:0] x);
    if (x > MAX48) begin
      return MAX48[47:0];
    end else if (x < MIN48) begin
      return MIN48[47:0];
    end
    return x[47:0];
  endfunction

  function automatic acc_t add_sat64(input acc_t a, input q40_t b);
    logic signed [64:0] s;
    s = {a[63], a} + {{17{b[47]}}, b};
    if (s[64] != s[63]) begin
      return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end
    return s[63:0];
  endfunction

  function automatic logic signed [31:0] round_pos(input acc_t p);
    acc_t pc;
    acc_t q;
    pc = p;
    if (pc > 64'sh7FFFFFFFFFFF7FFF) begin
      pc = 64'sh7FFFFFFFFFFF7FFF;
    end
    q = (pc + 64'sd32768) >>> 16;
    if (q > 64'sh000000007FFFFFFF) begin
      return 32'sh7FFFFFFF;
    end else if (q < -64'sh0000000080000000) begin
      return 32'sh80000000;
    end
    return q[31:0];
  endfunction

  state_t state_r;

  logic                 dbl_r;
  logic [9:0]           accel_cfg_r;
  logic [9:0]           settle_r;
  logic [15:0]          min_dur_r;

  logic [TICK_BITS-1:0] tick_r;
  logic [TICK_BITS-1:0] end_time_r;
  logic [TICK_BITS-1:0] linear_end_r;
  logic [TICK_BITS-1:0] decel_end_r;
  logic [9:0]           lat_accel_r;
  logic                 fin_r;
  logic [1:0]           j_r;
  logic [32:0]          dmax_r;

  logic signed [32:0]   dist_r   [NUM_JOINTS];
  q40_t                 jacc_r   [NUM_JOINTS];
  q40_t                 jvel_r   [NUM_JOINTS];
  acc_t                 jpos_r   [NUM_JOINTS];
  logic signed [31:0]   jtgt_r   [NUM_JOINTS];
  q40_t                 cmd_r    [NUM_JOINTS];

  logic [63:0]          dv_num_r;
  logic [47:0]          dv_rem_r;
  logic [47:0]          dv_den_r;
  logic [5:0]           dv_cnt_r;

  logic                 out_valid_r;
  logic [1:0]           out_joint_r;
  logic signed [31:0]   out_pos_r;
  q40_t                 out_vel_r;
  q40_t                 out_acc_r;
  logic                 out_last_r;
  logic                 out_fin_r;

  logic signed [31:0]   sp [NUM_JOINTS];
  logic signed [31:0]   tp [NUM_JOINTS];
  logic [32:0]          dabs [NUM_JOINTS];

  logic [48:0]          dv_sh;
  logic                 dv_ge;
  logic [48:0]          dv_diff;

  logic [TICK_BITS-1:0] tick_inc;
  logic [22:0]          dur_raw;
  logic [22:0]          dur_min;
  logic [TICK_BITS-1:0] dec_end;
  logic [TICK_BITS-1:0] lin_end;
  logic [TICK_BITS-1:0] lin_div;
  logic [9:0]           acc_div;

  q40_t                 ja;
  q40_t                 jv;
  q40_t                 v_up;
  q40_t                 v_dn;
  q40_t                 v_cst;
  q40_t                 a_neg;
  logic signed [58:0]   cst_prod;
  q40_t                 v_new;
  q40_t                 c_new;
  acc_t                 p_new;

  logic [48:0]          q49;
  logic signed [63:0]   a_sgn;
  logic                 tout_go;

  always_comb begin
    sp[0] = in_start_pos_0; sp[1] = in_start_pos_1;
    sp[2] = in_start_pos_2; sp[3] = in_start_pos_3;
    tp[0] = in_target_0; tp[1] = in_target_1;
    tp[2] = in_target_2; tp[3] = in_target_3;
    for (int k = 0; k < NUM_JOINTS; k++) begin
      dabs[k] = dist_r[k][32] ? 33'(-dist_r[k]) : 33'(dist_r[k]);
    end
  end

  assign dv_sh   = {dv_rem_r, dv_num_r[63]};
  assign dv_ge   = dv_sh >= {1'b0, dv_den_r};
  assign dv_diff = dv_sh - {1'b0, dv_den_r};

  assign tick_inc = (tick_r < TICK_MAX) ? tick_r + 1'b1 : tick_r;
  assign dur_raw  = dbl_r ? {dv_num_r[21:0], 1'b0} : {1'b0, dv_num_r[21:0]};
  assign dur_min  = (dur_raw < {7'd0, min_dur_r}) ? {7'd0, min_dur_r} : dur_raw;
  assign dec_end  = (end_time_r > {14'd0, settle_r}) ? end_time_r - {14'd0, settle_r}
                                                     : '0;
  assign lin_end  = (dec_end > {14'd0, lat_accel_r}) ? dec_end - {14'd0, lat_accel_r}
                                                     : '0;
  assign lin_div  = (linear_end_r == '0) ? TICK_BITS'(1) : linear_end_r;
  assign acc_div  = (lat_accel_r == '0) ? 10'd1 : lat_accel_r;

  always_comb begin
    ja       = jacc_r[j_r];
    jv       = jvel_r[j_r];
    v_up     = sat48(64'(jv) + 64'(ja));
    v_dn     = sat48(64'(jv) - 64'(ja));
    a_neg    = sat48(-64'(ja));
    cst_prod = $signed({1'b0, lat_accel_r}) * ja;
    v_cst    = sat48(64'(cst_prod));
    if ({14'd0, lat_accel_r} >= tick_r) begin
      v_new = v_up;
      c_new = ja;
    end else if (linear_end_r >= tick_r) begin
      v_new = v_cst;
      c_new = '0;
    end else begin
      v_new = v_dn;
      c_new = a_neg;
    end
    p_new = add_sat64(jpos_r[j_r], v_new);
  end

  always_comb begin
    q49   = (dv_num_r[63:48] != '0) ? 49'h1_0000_0000_0000 : {1'b0, dv_num_r[47:0]};
    if (q49 > 49'(MAX48)) begin
      q49 = 49'h1_0000_0000_0000;
    end
    a_sgn = dist_r[j_r][32] ? -64'(q49) : 64'(q49);
  end

  assign tout_go = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dbl_r       <= 1'b0;
      accel_cfg_r <= 10'd100;
      settle_r    <= 10'd10;
      min_dur_r   <= 16'd200;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DOUBLE: dbl_r       <= cfg_data[0];
        CFG_ACCEL:  accel_cfg_r <= cfg_data[9:0];
        CFG_SETTLE: settle_r    <= cfg_data[9:0];
        CFG_MINDUR: min_dur_r   <= cfg_data;
        default:    dbl_r       <= dbl_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_TOUT && tout_go) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      tick_r       <= '0;
      end_time_r   <= '0;
      linear_end_r <= '0;
      decel_end_r  <= '0;
      lat_accel_r  <= '0;
      fin_r        <= 1'b0;
      j_r          <= '0;
      for (int k = 0; k < NUM_JOINTS; k++) begin
        jacc_r[k] <= '0;
        jvel_r[k] <= '0;
        jpos_r[k] <= '0;
        jtgt_r[k] <= '0;
        cmd_r[k]  <= '0;
      end
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            if (!in_action) begin
              for (int k = 0; k < NUM_JOINTS; k++) begin
                dist_r[k] <= 33'(tp[k]) - 33'(sp[k]);
                jpos_r[k] <= {{16{sp[k][31]}}, sp[k], 16'd0};
                jvel_r[k] <= '0;
                cmd_r[k]  <= '0;
                jtgt_r[k] <= tp[k];
              end
              state_r <= ST_DMAX;
            end else begin
              tick_r  <= tick_inc;
              fin_r   <= tick_inc > end_time_r;
              j_r     <= '0;
              state_r <= ST_TUPD;
            end
          end
        end
        ST_DMAX: begin
          begin
            logic [32:0] m01;
            logic [32:0] m23;
            m01 = (dabs[0] > dabs[1]) ? dabs[0] : dabs[1];
            m23 = (dabs[2] > dabs[3]) ? dabs[2] : dabs[3];
            dmax_r <= (m01 > m23) ? m01 : m23;
          end
          state_r <= ST_TMUL;
        end
        ST_TMUL: begin
          dv_num_r <= 64'(dmax_r) * 64'(DUR_SCALE);
          dv_den_r <= PI_Q40;
          dv_rem_r <= '0;
          dv_cnt_r <= '0;
          state_r  <= ST_TDIV;
        end
        ST_TDIV, ST_JDIV: begin
          dv_rem_r <= dv_ge ? dv_diff[47:0] : dv_sh[47:0];
          dv_num_r <= {dv_num_r[62:0], dv_ge};
          dv_cnt_r <= dv_cnt_r + 1'b1;
          if (dv_cnt_r == 6'd63) begin
            state_r <= (state_r == ST_TDIV) ? ST_DUR : ST_JSTORE;
          end
        end
        ST_DUR: begin
          end_time_r  <= (24'(dur_min) > TICK_MAX) ? TICK_MAX : 24'(dur_min);
          tick_r      <= '0;
          lat_accel_r <= accel_cfg_r;
          state_r     <= ST_LIMS;
        end
        ST_LIMS: begin
          decel_end_r  <= dec_end;
          linear_end_r <= lin_end;
          state_r      <= ST_DPROD;
        end
        ST_DPROD: begin
          dv_den_r <= 48'(lin_div) * 48'(acc_div);
          j_r      <= '0;
          state_r  <= ST_JLOAD;
        end
        ST_JLOAD: begin
          dv_num_r <= 64'({dabs[j_r], 16'd0}) + 64'(dv_den_r >> 1);
          dv_rem_r <= '0;
          dv_cnt_r <= '0;
          state_r  <= ST_JDIV;
        end
        ST_JSTORE: begin
          jacc_r[j_r] <= sat48(a_sgn);
          if (j_r == 2'(NUM_JOINTS - 1)) begin
            state_r <= ST_IDLE;
          end else begin
            j_r     <= j_r + 1'b1;
            state_r <= ST_JLOAD;
          end
        end
        ST_TUPD: begin
          if (!fin_r) begin
            if (tick_r <= decel_end_r || {14'd0, lat_accel_r} >= tick_r) begin
              jvel_r[j_r] <= v_new;
              jpos_r[j_r] <= p_new;
              cmd_r[j_r]  <= c_new;
            end else begin
              jvel_r[j_r] <= '0;
              jpos_r[j_r] <= {{16{jtgt_r[j_r][31]}}, jtgt_r[j_r], 16'd0};
              cmd_r[j_r]  <= '0;
            end
          end
          state_r <= ST_TOUT;
        end
        ST_TOUT: begin
          if (tout_go) begin
            out_joint_r <= j_r;
            out_pos_r   <= round_pos(jpos_r[j_r]);
            out_vel_r   <= jvel_r[j_r];
            out_acc_r   <= cmd_r[j_r];
            out_last_r  <= (j_r == 2'(NUM_JOINTS - 1));
            out_fin_r   <= fin_r;
            if (j_r == 2'(NUM_JOINTS - 1)) begin
              state_r <= ST_IDLE;
            end else begin
              j_r     <= j_r + 1'b1;
              state_r <= ST_TUPD;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_stall         = (state_r != ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_joint        = out_joint_r;
  assign out_position     = out_pos_r;
  assign out_velocity     = out_vel_r;
  assign out_acceleration = out_acc_r;
  assign out_last         = out_last_r;
  assign out_finished     = out_fin_r;

endmodule

// ===== hdl/atm_checker.sv =====
// Port-level checker for the trapezoid move block and its bind.
`include "absolute_trapezoid_move_macros.svh"
module atm_checker import atm_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_joint,
  input logic [31:0] out_position,
  input logic        out_last
);

  `ATM_ASSERT_NEXT(a_busy_after_req, in_valid && !in_stall, in_stall)
  `ATM_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_position))
  `ATM_ASSERT_NOW(a_last_joint, out_valid && out_last, out_joint == 2'(NUM_JOINTS - 1))
  `ATM_ASSERT_NOW(a_not_last, out_valid && !out_last, out_joint != 2'(NUM_JOINTS - 1))

endmodule

bind absolute_trapezoid_move atm_checker u_atm_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .out_joint    (out_joint),
  .out_position (out_position),
  .out_last     (out_last)
);
